[hw/rtl/k_weighted_block_energy_defines.svh]
// Assertion macros shared by the block energy RTL.
`ifndef K_WEIGHTED_BLOCK_ENERGY_DEFINES_SVH
`define K_WEIGHTED_BLOCK_ENERGY_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define KWBE_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("kwbe check failed");

// Check that a condition implies another in the same cycle.
`define KWBE_CHECK_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kwbe implication failed");

// Check that a condition implies another in the next cycle.
`define KWBE_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kwbe sequence failed");

`endif

[hw/rtl/kwbe_pkg.sv]
// Shared constants, types and arithmetic helpers of the block energy meter.
package kwbe_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_STEPS    = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int CH_W         = 3;
    localparam int STEP_W       = 3;
    localparam int ZADDR_W      = 5;
    localparam int ZDEPTH       = 32;

    localparam logic [1:0] REG_CHANNEL_COUNT    = 2'd0;
    localparam logic [1:0] REG_STEP_FRAMES      = 2'd1;
    localparam logic [1:0] REG_STEPS_PER_WINDOW = 2'd2;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    // Q.28 coefficients; stage 0 is the shelf, stage 1 the high-pass.
    // Index: b0, b1, b2, a1, a2.
    function automatic logic signed [31:0] coef(input logic stg, input logic [2:0] k);
        logic signed [31:0] c;
        c = 32'sd0;
        if (!stg) begin
            case (k)
                3'd0: c = 32'sd412081942;
                3'd1: c = -32'sd722546694;
                3'd2: c = 32'sd321691121;
                3'd3: c = -32'sd453832898;
                3'd4: c = 32'sd196623811;
                default: c = 32'sd0;
            endcase
        end else begin
            case (k)
                3'd0: c = 32'sd268435456;
                3'd1: c = -32'sd536870912;
                3'd2: c = 32'sd268435456;
                3'd3: c = -32'sd534199296;
                3'd4: c = 32'sd265770496;
                default: c = 32'sd0;
            endcase
        end
        return c;
    endfunction

    // Round a product to Q.28: add half, floor.
    function automatic logic signed [35:0] rq28(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd134217728;
        return t[63:28];
    endfunction

    function automatic logic signed [32:0] sat33(input logic signed [41:0] v);
        if (v > 42'sd4294967295) return 33'sh0_FFFF_FFFF;
        if (v < -42'sd4294967296) return 33'sh1_0000_0000;
        return v[32:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        if (v > 42'sd549755813887) return 40'sh7F_FFFF_FFFF;
        if (v < -42'sd549755813888) return 40'sh80_0000_0000;
        return v[39:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607) return 24'sh7F_FFFF;
        if (v < -28'sd8388608) return 24'sh80_0000;
        return v[23:0];
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

endpackage

[hw/rtl/kwbe_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module kwbe_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_dividend,
    input  logic [18:0]        i_divisor,
    output kwbe_pkg::t_div_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_quo;
    logic [18:0] r_rem;
    logic [18:0] r_div;
    logic [19:0] trial;
    logic [19:0] diff;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_quo[63]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= 19'd0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            r_rem <= ge ? diff[18:0] : trial[18:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[hw/rtl/k_weighted_block_energy.sv]
// Top level of the K-weighted block energy meter.
// Usage:
//   s_* carries one 48 kHz frame per item: eight signed Q1.23 samples in
//   s_tdata and the final-frame mark in s_tlast. m_* carries at most one
//   result per frame: window mean square (Q6.34, saturating), window length
//   in frames, and s_tlast's echo as m_tlast for the final window.
//   The APB port sets channel_count (0x0), step_frames (0x4) and
//   steps_per_window (0x8); write it only while the block is idle.
// Sequencing:
//   Channels are filtered one after another through one shared multiplier
//   (two biquads per channel plus squaring), and a frame is filtered in
//   full before the next one is accepted. When a window closes or the final
//   frame arrives, up to 7 stored step sums are added one a cycle and a
//   bit-serial divider then holds the sequence until its quotient is done.
//   Filter delays sit in a 32-entry memory with per-entry valid bits.
// Reset and stall:
//   Reset clears filters and step state at once and restores register
//   defaults; the final frame does the same to filters and step state.
//   The result waits in an output register; the next frame is accepted
//   meanwhile and only holds at its own result until the register frees.
`include "k_weighted_block_energy_defines.svh"

module k_weighted_block_energy (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // sample_0 [23:0] .. sample_7 [191:168]
    input  logic [191:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    // block_energy [39:0], block_length [58:40], zero pad [63:59]
    output logic [63:0]  m_tdata,
    output logic         m_tvalid,
    output logic         m_tlast,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FILT  = 7'b0000010,
        S_POST  = 7'b0000100,
        S_RING  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_CLOSE = 7'b1000000
    } t_state;

    t_state r_state;

    // configuration
    logic [3:0]  r_cfg_cc;
    logic [15:0] r_cfg_sf;
    logic [3:0]  r_cfg_spw;
    logic [3:0]  nch_eff;
    logic [15:0] sf_eff;
    logic [3:0]  spw_eff;
    logic        cfg_we;

    // frame and sequencer
    logic signed [23:0] r_smp [kwbe_pkg::MAX_CHANNELS];
    logic               r_last;
    logic [2:0]         r_ch;
    logic [3:0]         r_ph;
    logic               stg;
    logic [3:0]         k4;
    logic [2:0]         k;

    // datapath
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [41:0] r_acc1;
    logic signed [41:0] r_acc2;
    logic signed [63:0] r_prod;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [35:0] prq;
    logic signed [39:0] z_rd;
    logic signed [33:0] y_rnd;
    logic signed [23:0] q;
    logic [49:0]        r_fsum;

    // filter delay memory
    logic signed [39:0] r_zmem [kwbe_pkg::ZDEPTH];
    logic signed [39:0] r_zrd;
    logic               r_zrd_ok;
    logic [kwbe_pkg::ZDEPTH-1:0] r_zvalid;
    logic               z_re;
    logic               z_we;
    logic [kwbe_pkg::ZADDR_W-1:0] z_addr;
    logic signed [39:0] z_wdata;

    // step state
    logic [63:0] r_smem [kwbe_pkg::MAX_STEPS];
    logic [63:0] r_srd;
    logic [63:0] r_cur;
    logic [15:0] r_fis;
    logic [3:0]  r_sd;
    logic [2:0]  r_head;
    logic [2:0]  r_cnt;
    logic [2:0]  r_ri;
    logic        r_pend;
    logic [63:0] r_acc;
    logic [18:0] r_len;
    logic        r_fin;
    logic        r_close;
    logic        s_re;
    logic [2:0]  s_raddr;
    logic [2:0]  prev_last;
    logic [18:0] len_calc;
    logic [2:0]  len_prev;

    // divider and output
    logic               r_div_start;
    kwbe_pkg::t_div_rsp div_rsp;
    logic [39:0]        r_energy;
    logic               r_mv;
    logic [63:0]        r_mdata;
    logic               r_mlast;
    logic               out_load;
    logic               s_acc;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cc  <= 4'd2;
            r_cfg_sf  <= 16'd4800;
            r_cfg_spw <= 4'd4;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                kwbe_pkg::REG_CHANNEL_COUNT:    r_cfg_cc  <= pwdata[3:0];
                kwbe_pkg::REG_STEP_FRAMES:      r_cfg_sf  <= pwdata[15:0];
                kwbe_pkg::REG_STEPS_PER_WINDOW: r_cfg_spw <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            kwbe_pkg::REG_CHANNEL_COUNT:    prdata = {28'd0, r_cfg_cc};
            kwbe_pkg::REG_STEP_FRAMES:      prdata = {16'd0, r_cfg_sf};
            kwbe_pkg::REG_STEPS_PER_WINDOW: prdata = {28'd0, r_cfg_spw};
            default:                        prdata = 32'd0;
        endcase
    end

    // clamp register values to their working ranges
    always_comb begin
        nch_eff = (r_cfg_cc == 4'd0) ? 4'd1 : (r_cfg_cc > 4'd8 ? 4'd8 : r_cfg_cc);
        sf_eff  = (r_cfg_sf == 16'd0) ? 16'd1 : r_cfg_sf;
        spw_eff = (r_cfg_spw == 4'd0) ? 4'd1 : (r_cfg_spw > 4'd8 ? 4'd8 : r_cfg_spw);
    end

    // ---------------- filter datapath ----------------
    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        stg  = (r_ph >= 4'd6);
        k4   = stg ? (r_ph - 4'd6) : r_ph;
        k    = k4[2:0];
        prq  = kwbe_pkg::rq28(r_prod);
        z_rd = r_zrd_ok ? r_zrd : 40'sd0;
        // round the high-pass output to Q2.22 and saturate
        y_rnd = {r_y[32], r_y} + 34'sd32;
        q     = kwbe_pkg::sat24(y_rnd[33:6]);
        if (r_ph == 4'd12) begin
            mul_a = {{9{q[23]}}, q};
            mul_b = {{8{q[23]}}, q};
        end else begin
            mul_a = (k < 3'd3) ? r_x : r_y;
            mul_b = kwbe_pkg::coef(stg, k);
        end
        // one delay read per cycle at the first two steps, writes at the last two
        z_re    = (r_state == S_FILT) && (r_ph < 4'd12) && (k < 3'd2);
        z_we    = (r_state == S_FILT) && (r_ph < 4'd12) && (k >= 3'd4);
        z_addr  = {r_ch, stg, k[0]};
        z_wdata = (k == 3'd4) ? kwbe_pkg::sat40(r_acc1 - 42'(prq))
                              : kwbe_pkg::sat40(r_acc2 - 42'(prq));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Each entry is read before it is written back within a channel, and the
    // next read of it comes a frame later, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (z_we) r_zmem[z_addr] <= z_wdata;
        if (z_re) r_zrd <= r_zmem[z_addr];
    end

    // ---------------- step ring memory ----------------
    always_comb begin
        s_re    = (r_state == S_RING) && (r_ri < r_cnt);
        s_raddr = r_head - 3'd1 - r_ri;
        prev_last = ({1'b0, r_sd} < {1'b0, spw_eff} - 5'd1) ? r_sd[2:0]
                                                           : 3'(spw_eff - 4'd1);
        len_prev  = r_last ? prev_last : 3'(spw_eff - 4'd1);
        len_calc  = 19'(r_fis) + 19'(len_prev) * 19'(sf_eff);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLOSE) r_smem[r_head] <= r_cur;
        if (s_re) r_srd <= r_smem[s_raddr];
    end

    // ---------------- divider ----------------
    kwbe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_len),
        .o_rsp      (div_rsp)
    );

    assign out_load = (r_state == S_OUT) && (!r_mv || m_tready);

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            for (int i = 0; i < kwbe_pkg::MAX_CHANNELS; i++) begin
                r_smp[i] <= s_tdata[i*kwbe_pkg::SAMPLE_BITS +: kwbe_pkg::SAMPLE_BITS];
            end
            r_x <= {{4{s_tdata[23]}}, s_tdata[23:0], 5'd0};
        end else if (r_state == S_FILT) begin
            unique case (k)
                3'd1: r_y <= kwbe_pkg::sat33(42'(prq) + 42'(z_rd));
                3'd2: r_acc1 <= 42'(prq) + 42'(z_rd);
                3'd3: r_acc2 <= 42'(prq);
                3'd5: if (!stg) r_x <= r_y;
                default: ;
            endcase
            // load the next channel's sample once squaring is done
            if (r_ph == 4'd13) begin
                r_x <= {{4{r_smp[3'(r_ch + 3'd1)][23]}}, r_smp[3'(r_ch + 3'd1)], 5'd0};
            end
        end
        if (div_rsp.done) begin
            r_energy <= (|div_rsp.quotient[63:50]) ? 40'hFF_FFFF_FFFF
                                                   : div_rsp.quotient[49:10];
        end
        if (out_load) begin
            r_mdata <= {5'd0, r_len, r_energy};
            r_mlast <= r_fin;
        end
        if (r_state == S_POST) r_len <= len_calc;
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_ch        <= 3'd0;
            r_ph        <= 4'd0;
            r_fsum      <= 50'd0;
            r_zvalid    <= '0;
            r_zrd_ok    <= 1'b0;
            r_cur       <= 64'd0;
            r_fis       <= 16'd0;
            r_sd        <= 4'd0;
            r_head      <= 3'd0;
            r_cnt       <= 3'd0;
            r_ri        <= 3'd0;
            r_pend      <= 1'b0;
            r_acc       <= 64'd0;
            r_fin       <= 1'b0;
            r_close     <= 1'b0;
            r_div_start <= 1'b0;
            r_mv        <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (z_re) r_zrd_ok <= r_zvalid[z_addr];
            if (z_we) r_zvalid[z_addr] <= 1'b1;
            if (out_load) r_mv <= 1'b1;
            else if (m_tready) r_mv <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_last  <= s_tlast;
                        r_ch    <= 3'd0;
                        r_ph    <= 4'd0;
                        r_fsum  <= 50'd0;
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (r_ph == 4'd13) begin
                        // sum only the active channels
                        logic [49:0] fs;
                        fs = r_fsum;
                        if ({1'b0, r_ch} < nch_eff) fs = r_fsum + 50'(r_prod[46:0]);
                        r_fsum <= fs;
                        r_ph   <= 4'd0;
                        r_ch   <= r_ch + 3'd1;
                        if (r_ch == 3'(kwbe_pkg::MAX_CHANNELS - 1)) begin
                            r_cur   <= kwbe_pkg::add_sat(r_cur, 64'(fs));
                            r_fis   <= r_fis + 16'd1;
                            r_state <= S_POST;
                        end
                    end else begin
                        r_ph <= r_ph + 4'd1;
                    end
                end
                S_POST: begin
                    r_acc  <= r_cur;
                    r_ri   <= 3'd0;
                    r_pend <= 1'b0;
                    r_fin  <= r_last;
                    if (r_last) begin
                        r_cnt   <= prev_last;
                        r_close <= 1'b0;
                        r_state <= S_RING;
                    end else if (r_fis >= sf_eff) begin
                        r_cnt   <= 3'(spw_eff - 4'd1);
                        r_close <= 1'b1;
                        r_state <= ({1'b0, r_sd} + 5'd1 >= {1'b0, spw_eff}) ? S_RING
                                                                           : S_CLOSE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RING: begin
                    // add the latest stored steps, newest first
                    if (r_pend) r_acc <= kwbe_pkg::add_sat(r_acc, r_srd);
                    if (r_ri < r_cnt) begin
                        r_ri   <= r_ri + 3'd1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        if (r_fin) begin
                            // final frame: drop filter and step state
                            r_zvalid <= '0;
                            r_cur    <= 64'd0;
                            r_fis    <= 16'd0;
                            r_sd     <= 4'd0;
                            r_head   <= 3'd0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= r_close ? S_CLOSE : S_IDLE;
                        end
                    end
                end
                S_CLOSE: begin
                    r_head  <= r_head + 3'd1;
                    if (r_sd < 4'(kwbe_pkg::MAX_STEPS)) r_sd <= r_sd + 4'd1;
                    r_cur   <= 64'd0;
                    r_fis   <= 16'd0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_mv;
    assign m_tdata  = r_mdata;
    assign m_tlast  = r_mlast;

    // ---------------- checks ----------------
    `KWBE_CHECK_IMP(a_div_in_div, div_rsp.done, r_state == S_DIV)
    `KWBE_CHECK(a_steps_bounded, r_sd <= 4'(kwbe_pkg::MAX_STEPS))
    `KWBE_CHECK_IMP(a_ring_bounded, r_state == S_RING, r_ri <= r_cnt)
    `KWBE_CHECK_NEXT(a_final_clears, out_load && r_fin,
                     r_sd == 4'd0 && r_fis == 16'd0 && r_zvalid == '0)

endmodule
